// ===== rtl/core/mrba_pkg.sv =====
package mrba_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RMW,
        ST_BASE_INIT,
        ST_BASE_NEXT,
        ST_SCAN,
        ST_BASE_RES,
        ST_BASE_COMMIT,
        ST_ENH_SEL,
        ST_ENH_RES,
        ST_OUT_LOAD,
        ST_OUT_WAIT,
        ST_CLEAR
    } state_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_NUM_GROUPS  = 3'd0,
        REG_NUM_BLOCKS  = 3'd1,
        REG_RATE_LEVEL0 = 3'd2,
        REG_RATE_LEVEL1 = 3'd3,
        REG_RATE_LEVEL2 = 3'd4,
        REG_RATE_LEVEL3 = 3'd5,
        REG_RATE_LEVEL4 = 3'd6
    } reg_index_t;

    // Stored code of an entry that has seen no report.
    localparam logic [4:0] NO_REPORT = 5'd16;

    // Highest rate level register.
    localparam logic [2:0] TOP_RATE_IDX = 3'd4;

    // Control strobes from the controller to the quality store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } qs_ctrl_t;

    // Bits per block for each CQI value.
    function automatic logic [9:0] cqi_bits(input logic [3:0] q);
        logic [9:0] v;
        case (q)
            4'd0:    v = 10'd0;
            4'd1:    v = 10'd16;
            4'd2:    v = 10'd16;
            4'd3:    v = 10'd32;
            4'd4:    v = 10'd56;
            4'd5:    v = 10'd88;
            4'd6:    v = 10'd120;
            4'd7:    v = 10'd144;
            4'd8:    v = 10'd208;
            4'd9:    v = 10'd280;
            4'd10:   v = 10'd328;
            4'd11:   v = 10'd408;
            4'd12:   v = 10'd488;
            4'd13:   v = 10'd552;
            4'd14:   v = 10'd616;
            default: v = 10'd616;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mrba_qstore.sv =====
module mrba_qstore #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrba_pkg::qs_ctrl_t ctrl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [3:0]        wr_data,
    output logic [4:0]        rd_data
);
    import mrba_pkg::*;

    logic [3:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [3:0]       mem_q_reg;
    logic             hit_q_reg;

    // Worst quality per group and block, one write and one read per cycle.
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Entry valid bits: an entry never written since the last clear reads as no report.
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clr) begin
            valid_reg <= '0;
            hit_q_reg <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                hit_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_q_reg ? {1'b0, mem_q_reg} : NO_REPORT;

endmodule

// ===== rtl/core/multicast_rb_allocator_core.sv =====
// Multicast resource block allocator.
// Input channel (s_valid/s_ready) carries CQI reports: group, block, quality
// and a final flag. Each report is a read-modify-write of the quality store
// that keeps the worst CQI per group and block: the store is read when the
// report is taken, then compared and written back, and s_ready stays low
// during the write back, so a new report is taken only after the last one.
// The report flagged final is stored first, then the allocation runs. Every
// allocation try scans the store at most once in CQI order; the base layer
// makes up to MAX_GROUPS * MAX_GROUPS tries and the enhancement phase one try
// per level step, and each winner selection steps through the groups in use.
// The result channel (m_valid/m_ready) then delivers one request per group in
// use, last_group set on the final one. The output register holds its values
// while m_ready is low; no new report is taken until all results are taken.
// After the last result the store is cleared, and the block
// returns to idle. Reset (aresetn low, synchronous) empties the store and
// loads the register defaults. Configuration writes (cfg_wr_en) take effect
// at once and are meant for idle periods.
module multicast_rb_allocator_core #(
    parameter int MAX_GROUPS = 4,
    parameter int MAX_BLOCKS = 64,
    parameter int NUM_LEVELS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_group_id,
    input  logic [5:0]  s_block_id,
    input  logic [3:0]  s_quality,
    input  logic        s_final_report,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_group,
    output logic        m_served,
    output logic [2:0]  m_level,
    output logic [6:0]  m_block_count,
    output logic [15:0] m_achieved_rate,
    output logic [63:0] m_block_mask,
    output logic        m_last_group
);
    import mrba_pkg::*;

    localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW   = $clog2(MAX_GROUPS + 1);
    localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int LW    = $clog2(NUM_LEVELS);
    localparam int DEPTH = MAX_GROUPS * MAX_BLOCKS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = CW + 11;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [2:0]  num_groups_reg;
    logic [6:0]  num_blocks_reg;
    logic [15:0] rate_level_reg [5];

    // Latched report.
    logic [GW-1:0] req_g_reg;
    logic [BW-1:0] req_b_reg;
    logic [3:0]    req_q_reg;
    logic          req_fin_reg;
    logic          req_hit_reg;

    // Allocation state.
    logic [GCW-1:0]        ng_reg;
    logic [CW-1:0]         nb_reg;
    logic [MAX_BLOCKS-1:0] free_reg;
    logic [MAX_BLOCKS-1:0] grp_blocks_reg [MAX_GROUPS];
    logic [15:0]           grp_rate_reg   [MAX_GROUPS];
    logic [LW-1:0]         grp_level_reg  [MAX_GROUPS];
    logic [CW-1:0]         grp_count_reg  [MAX_GROUPS];
    logic [MAX_GROUPS-1:0] grp_active_reg;
    logic [MAX_GROUPS-1:0] grp_served_reg;
    logic [MAX_GROUPS-1:0] grp_done_reg;
    logic [GCW-1:0]        cur_g_reg;

    // Base layer winner of the current round.
    logic                  found_reg;
    logic [GW-1:0]         win_g_reg;
    logic [MAX_BLOCKS-1:0] win_mask_reg;
    logic [15:0]           win_rate_reg;
    logic [CW-1:0]         win_cnt_reg;

    // Enhancement candidate.
    logic          best_found_reg;
    logic [GW-1:0] best_g_reg;
    logic [15:0]   best_n_reg;
    logic [CW-1:0] best_d_reg;
    logic [CW-1:0] best_cnt_reg;
    logic [LW-1:0] best_level_reg;

    // Scan of one allocation try.
    logic [3:0]            scan_q_reg;
    logic [BW-1:0]         scan_b_reg;
    logic                  scan_end_reg;
    logic                  p_valid_reg;
    logic [BW-1:0]         p_b_reg;
    logic [3:0]            p_q_reg;
    logic [CW-1:0]         scan_k_reg;
    logic [MAX_BLOCKS-1:0] scan_mask_reg;
    logic [15:0]           scan_rate_reg;
    logic                  scan_ok_reg;
    logic [15:0]           scan_target_reg;
    logic [CW-1:0]         scan_held_reg;
    logic                  scan_enh_reg;

    // Output register.
    logic        m_valid_reg;
    logic [1:0]  out_group_reg;
    logic        out_served_reg;
    logic [2:0]  out_level_reg;
    logic [6:0]  out_count_reg;
    logic [15:0] out_rate_reg;
    logic [63:0] out_mask_reg;
    logic        out_last_reg;

    // Quality store port.
    qs_ctrl_t      qs_ctrl;
    logic [AW-1:0] qs_rd_addr;
    logic [AW-1:0] qs_wr_addr;
    logic [4:0]    qs_rd_data;

    mrba_qstore #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_qstore (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (qs_ctrl),
        .rd_addr (qs_rd_addr),
        .wr_addr (qs_wr_addr),
        .wr_data (req_q_reg),
        .rd_data (qs_rd_data)
    );

    logic [GW-1:0]   cur_i;
    logic            at_end;
    logic            s_acc;
    logic            in_range;
    logic [3:0]      cqi_eval;
    logic            blk_ok;
    logic [CW-1:0]   take_k;
    logic [CW:0]     take_sum;
    logic [PW-1:0]   take_prod;
    logic            take_hit;
    logic            scan_fail;
    logic [LW:0]     nxt_lvl;
    logic [2:0]      enh_idx;
    logic [15:0]     enh_target;
    logic [15:0]     cur_n;
    logic [CW-1:0]   cur_d;
    logic [16+CW-1:0] prod_a;
    logic [16+CW-1:0] prod_b;
    logic            better;
    logic            out_last;

    assign cur_i    = cur_g_reg[GW-1:0];
    assign at_end   = (cur_g_reg == ng_reg);
    assign s_acc    = s_valid && s_ready;
    assign in_range = (int'(s_group_id) < MAX_GROUPS) && (int'(s_block_id) < MAX_BLOCKS);

    // Evaluation stage of the scan: one block per cycle in CQI order.
    assign cqi_eval  = (qs_rd_data > 5'd15) ? 4'd0 : qs_rd_data[3:0];
    assign blk_ok    = p_valid_reg && free_reg[p_b_reg] && (CW'(p_b_reg) < nb_reg)
                       && (cqi_eval == p_q_reg);
    assign take_k    = scan_k_reg + CW'(1);
    assign take_sum  = (CW + 1)'(scan_held_reg) + (CW + 1)'(take_k);
    assign take_prod = PW'(take_sum) * PW'(cqi_bits(p_q_reg));
    assign take_hit  = blk_ok && (32'(take_prod) >= 32'(scan_target_reg));
    assign scan_fail = scan_end_reg && !p_valid_reg;

    // Next level target, capped at the top rate register.
    assign nxt_lvl    = (LW + 1)'(best_level_reg) + (LW + 1)'(1);
    assign enh_idx    = (int'(nxt_lvl) > int'(TOP_RATE_IDX)) ? TOP_RATE_IDX : 3'(nxt_lvl);
    assign enh_target = rate_level_reg[enh_idx];

    // Rate per block of the current group against the best so far (cross products).
    assign cur_n  = (grp_count_reg[cur_i] == '0) ? 16'd0 : grp_rate_reg[cur_i];
    assign cur_d  = (grp_count_reg[cur_i] == '0) ? CW'(1) : grp_count_reg[cur_i];
    assign prod_a = (16 + CW)'(cur_n) * (16 + CW)'(best_d_reg);
    assign prod_b = (16 + CW)'(best_n_reg) * (16 + CW)'(cur_d);
    assign better = !best_found_reg || (prod_a > prod_b);

    assign out_last = ((cur_g_reg + GCW'(1)) == ng_reg);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and store control.
    always_comb begin
        state_next    = state_reg;
        qs_ctrl       = '0;
        qs_rd_addr    = AW'(int'(cur_i) * MAX_BLOCKS + int'(scan_b_reg));
        qs_wr_addr    = AW'(int'(req_g_reg) * MAX_BLOCKS + int'(req_b_reg));
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                qs_rd_addr    = AW'(int'(GW'(s_group_id)) * MAX_BLOCKS + int'(BW'(s_block_id)));
                qs_ctrl.rd_en = s_valid;
                if (s_valid) begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                qs_ctrl.wr_en = req_hit_reg && ({1'b0, req_q_reg} < qs_rd_data);
                state_next    = req_fin_reg ? ST_BASE_INIT : ST_IDLE;
            end
            ST_BASE_INIT: begin
                state_next = ST_BASE_NEXT;
            end
            ST_BASE_NEXT: begin
                if (at_end) begin
                    state_next = found_reg ? ST_BASE_COMMIT : ST_ENH_SEL;
                end else if (!grp_done_reg[cur_i]) begin
                    state_next = (rate_level_reg[0] == 16'd0) ? ST_BASE_RES : ST_SCAN;
                end
            end
            ST_SCAN: begin
                qs_ctrl.rd_en = !scan_end_reg;
                if (take_hit || scan_fail) begin
                    state_next = scan_enh_reg ? ST_ENH_RES : ST_BASE_RES;
                end
            end
            ST_BASE_RES: begin
                state_next = ST_BASE_NEXT;
            end
            ST_BASE_COMMIT: begin
                state_next = ST_BASE_NEXT;
            end
            ST_ENH_SEL: begin
                if (free_reg == '0) begin
                    state_next = ST_OUT_LOAD;
                end else if (at_end) begin
                    if (!best_found_reg) begin
                        state_next = ST_OUT_LOAD;
                    end else begin
                        state_next = (enh_target == 16'd0) ? ST_ENH_RES : ST_SCAN;
                    end
                end
            end
            ST_ENH_RES: begin
                state_next = ST_ENH_SEL;
            end
            ST_OUT_LOAD: begin
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    state_next = m_last_group ? ST_CLEAR : ST_OUT_LOAD;
                end
            end
            ST_CLEAR: begin
                qs_ctrl.clr = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_groups_reg    <= 3'd3;
            num_blocks_reg    <= 7'd50;
            rate_level_reg[0] <= 16'd100;
            rate_level_reg[1] <= 16'd375;
            rate_level_reg[2] <= 16'd750;
            rate_level_reg[3] <= 16'd1750;
            rate_level_reg[4] <= 16'd3000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NUM_GROUPS:  num_groups_reg    <= cfg_wdata[2:0];
                REG_NUM_BLOCKS:  num_blocks_reg    <= cfg_wdata[6:0];
                REG_RATE_LEVEL0: rate_level_reg[0] <= cfg_wdata;
                REG_RATE_LEVEL1: rate_level_reg[1] <= cfg_wdata;
                REG_RATE_LEVEL2: rate_level_reg[2] <= cfg_wdata;
                REG_RATE_LEVEL3: rate_level_reg[3] <= cfg_wdata;
                REG_RATE_LEVEL4: rate_level_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Report latch.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_g_reg   <= GW'(s_group_id);
            req_b_reg   <= BW'(s_block_id);
            req_q_reg   <= s_quality;
            req_fin_reg <= s_final_report;
            req_hit_reg <= in_range;
        end
    end

    // Allocation datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ng_reg         <= GCW'(1);
            nb_reg         <= CW'(1);
            free_reg       <= '0;
            grp_active_reg <= '0;
            grp_served_reg <= '0;
            grp_done_reg   <= '0;
            cur_g_reg      <= '0;
            found_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            scan_end_reg   <= 1'b0;
            p_valid_reg    <= 1'b0;
            scan_ok_reg    <= 1'b0;
            scan_enh_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                grp_blocks_reg[g] <= '0;
            end
        end else begin
            case (state_reg)
                ST_BASE_INIT: begin
                    if (num_groups_reg == 3'd0) begin
                        ng_reg <= GCW'(1);
                    end else if (int'(num_groups_reg) > MAX_GROUPS) begin
                        ng_reg <= GCW'(MAX_GROUPS);
                    end else begin
                        ng_reg <= GCW'(num_groups_reg);
                    end
                    if (num_blocks_reg == 7'd0) begin
                        nb_reg <= CW'(1);
                    end else if (int'(num_blocks_reg) > MAX_BLOCKS) begin
                        nb_reg <= CW'(MAX_BLOCKS);
                    end else begin
                        nb_reg <= CW'(num_blocks_reg);
                    end
                    for (int i = 0; i < MAX_BLOCKS; i++) begin
                        free_reg[i] <= (num_blocks_reg == 7'd0) ? (i == 0)
                                       : (i < int'(num_blocks_reg));
                    end
                    for (int g = 0; g < MAX_GROUPS; g++) begin
                        grp_blocks_reg[g] <= '0;
                        grp_rate_reg[g]   <= '0;
                        grp_level_reg[g]  <= '0;
                        grp_count_reg[g]  <= '0;
                    end
                    grp_active_reg <= '0;
                    grp_served_reg <= '0;
                    grp_done_reg   <= '0;
                    cur_g_reg      <= '0;
                    found_reg      <= 1'b0;
                end
                ST_BASE_NEXT: begin
                    if (at_end) begin
                        if (found_reg) begin
                            cur_g_reg <= GCW'(win_g_reg);
                        end else begin
                            cur_g_reg      <= '0;
                            best_found_reg <= 1'b0;
                        end
                    end else if (grp_done_reg[cur_i]) begin
                        cur_g_reg <= cur_g_reg + GCW'(1);
                    end else begin
                        // Start a base layer try from no held blocks.
                        scan_q_reg      <= 4'd15;
                        scan_b_reg      <= '0;
                        scan_end_reg    <= 1'b0;
                        p_valid_reg     <= 1'b0;
                        scan_k_reg      <= '0;
                        scan_mask_reg   <= '0;
                        scan_rate_reg   <= '0;
                        scan_ok_reg     <= 1'b1;
                        scan_target_reg <= rate_level_reg[0];
                        scan_held_reg   <= '0;
                        scan_enh_reg    <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // Issue stage: walk blocks upward inside each CQI, CQI downward.
                    p_valid_reg <= !scan_end_reg;
                    p_b_reg     <= scan_b_reg;
                    p_q_reg     <= scan_q_reg;
                    if (!scan_end_reg) begin
                        if (scan_b_reg == BW'(MAX_BLOCKS - 1)) begin
                            scan_b_reg <= '0;
                            if (scan_q_reg == 4'd0) begin
                                scan_end_reg <= 1'b1;
                            end else begin
                                scan_q_reg <= scan_q_reg - 4'd1;
                            end
                        end else begin
                            scan_b_reg <= scan_b_reg + BW'(1);
                        end
                    end
                    // Evaluation stage: take a matching free block.
                    if (blk_ok) begin
                        scan_k_reg             <= take_k;
                        scan_mask_reg[p_b_reg] <= 1'b1;
                        scan_rate_reg          <= 16'(take_prod);
                    end
                    if (!take_hit && scan_fail) begin
                        scan_ok_reg <= 1'b0;
                    end
                end
                ST_BASE_RES: begin
                    if (scan_ok_reg) begin
                        if (!found_reg || (scan_k_reg < win_cnt_reg)) begin
                            found_reg    <= 1'b1;
                            win_g_reg    <= cur_i;
                            win_mask_reg <= scan_mask_reg;
                            win_rate_reg <= scan_rate_reg;
                            win_cnt_reg  <= scan_k_reg;
                        end
                    end else begin
                        grp_done_reg[cur_i] <= 1'b1;
                    end
                    cur_g_reg <= cur_g_reg + GCW'(1);
                end
                ST_BASE_COMMIT: begin
                    grp_done_reg[cur_i]   <= 1'b1;
                    grp_served_reg[cur_i] <= 1'b1;
                    grp_active_reg[cur_i] <= 1'b1;
                    grp_blocks_reg[cur_i] <= win_mask_reg;
                    grp_rate_reg[cur_i]   <= win_rate_reg;
                    grp_count_reg[cur_i]  <= win_cnt_reg;
                    free_reg              <= free_reg & ~win_mask_reg;
                    cur_g_reg             <= '0;
                    found_reg             <= 1'b0;
                end
                ST_ENH_SEL: begin
                    if (free_reg == '0 || (at_end && !best_found_reg)) begin
                        cur_g_reg <= '0;
                    end else if (at_end) begin
                        // Start an enhancement try for the chosen group.
                        cur_g_reg       <= GCW'(best_g_reg);
                        scan_q_reg      <= 4'd15;
                        scan_b_reg      <= '0;
                        scan_end_reg    <= 1'b0;
                        p_valid_reg     <= 1'b0;
                        scan_k_reg      <= '0;
                        scan_mask_reg   <= '0;
                        scan_rate_reg   <= '0;
                        scan_ok_reg     <= 1'b1;
                        scan_target_reg <= enh_target;
                        scan_held_reg   <= best_cnt_reg;
                        scan_enh_reg    <= 1'b1;
                    end else begin
                        if (grp_active_reg[cur_i] && better) begin
                            best_found_reg <= 1'b1;
                            best_g_reg     <= cur_i;
                            best_n_reg     <= cur_n;
                            best_d_reg     <= cur_d;
                            best_cnt_reg   <= grp_count_reg[cur_i];
                            best_level_reg <= grp_level_reg[cur_i];
                        end
                        cur_g_reg <= cur_g_reg + GCW'(1);
                    end
                end
                ST_ENH_RES: begin
                    if (scan_ok_reg) begin
                        grp_blocks_reg[cur_i] <= grp_blocks_reg[cur_i] | scan_mask_reg;
                        grp_rate_reg[cur_i]   <= scan_rate_reg;
                        grp_level_reg[cur_i]  <= grp_level_reg[cur_i] + LW'(1);
                        grp_count_reg[cur_i]  <= grp_count_reg[cur_i] + scan_k_reg;
                        free_reg              <= free_reg & ~scan_mask_reg;
                        if (int'(grp_level_reg[cur_i]) + 1 >= NUM_LEVELS - 1) begin
                            grp_active_reg[cur_i] <= 1'b0;
                        end
                    end else begin
                        grp_active_reg[cur_i] <= 1'b0;
                    end
                    cur_g_reg      <= '0;
                    best_found_reg <= 1'b0;
                end
                ST_OUT_LOAD: begin
                    m_valid_reg    <= 1'b1;
                    out_group_reg  <= 2'(cur_g_reg);
                    out_served_reg <= grp_served_reg[cur_i];
                    out_last_reg   <= out_last;
                    if (grp_served_reg[cur_i]) begin
                        out_level_reg <= 3'(grp_level_reg[cur_i]);
                        out_count_reg <= 7'(grp_count_reg[cur_i]);
                        out_rate_reg  <= grp_rate_reg[cur_i];
                        out_mask_reg  <= 64'(grp_blocks_reg[cur_i]);
                    end else begin
                        out_level_reg <= '0;
                        out_count_reg <= '0;
                        out_rate_reg  <= '0;
                        out_mask_reg  <= '0;
                    end
                end
                ST_OUT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        cur_g_reg   <= cur_g_reg + GCW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_group     = out_group_reg;
    assign m_served        = out_served_reg;
    assign m_level         = out_level_reg;
    assign m_block_count   = out_count_reg;
    assign m_achieved_rate = out_rate_reg;
    assign m_block_mask    = out_mask_reg;
    assign m_last_group    = out_last_reg;

    // The scan's block count always matches the blocks it has marked.
    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ($countones(scan_mask_reg) == int'(scan_k_reg)))
        else $error("scan count differs from scan mask");

    // A block held by the current group is never also free.
    a_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_reg & grp_blocks_reg[cur_i]) == '0)
        else $error("group block still marked free");

    // Reports and results never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("report taken while a result is pending");

    // The last result is followed by the store clear.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_group) |=> (state_reg == ST_CLEAR))
        else $error("store not cleared after last result");

    // Scanned blocks are taken only from the free set.
    a_scan_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ((scan_mask_reg & ~free_reg) == '0))
        else $error("scan took a block that is not free");

endmodule
